FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL module.
// No dependencies; compiled away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define DPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define DPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/dps_pkg.sv
// Package for the decagon prism vertex sampler: widths, constants, types, helpers.
// No dependencies; imported by every module of the block.
`default_nettype none
package dps_pkg;

    localparam int RAND_BITS   = 16;
    localparam int COORD_BITS  = 24;
    localparam int NSTAGE      = 8;
    localparam int Z_DLY       = NSTAGE - 4;
    localparam int APO_BITS    = 23;
    localparam int LEN_BITS    = 23;
    localparam int ORG_BITS    = 24;
    localparam int SEC_BITS    = 4;
    localparam int REGION_BITS = 2;
    localparam int ADDR_BITS   = 5;
    localparam int DATA_BITS   = 32;
    localparam int NREG        = 5;

    localparam int TAN_BITS   = 23;
    localparam logic [TAN_BITS-1:0] TAN18_Q24 = TAN_BITS'(5451248);
    localparam int TAN_SHIFT  = 16;
    localparam int TPROD_BITS = APO_BITS + TAN_BITS;
    localparam int T_BITS     = TPROD_BITS - TAN_SHIFT;

    localparam int FRAC_BITS = RAND_BITS + 1;
    localparam logic [FRAC_BITS-1:0] FRAC_ONE = FRAC_BITS'(1) << RAND_BITS;

    localparam int YPROD_BITS = FRAC_BITS + APO_BITS;
    localparam int Y0_BITS    = YPROD_BITS - RAND_BITS;
    localparam int XPROD_BITS = FRAC_BITS + T_BITS + 1;
    localparam int X0_SHIFT   = RAND_BITS + 8;
    localparam int X0_BITS    = XPROD_BITS - X0_SHIFT;

    localparam int TRIG_BITS = 32;
    localparam int ROT_BITS  = Y0_BITS + 1 + TRIG_BITS + 1;
    localparam int ROT_SHIFT = 30;
    localparam int SUM_BITS  = ROT_BITS - ROT_SHIFT;

    localparam int    SLAB_UNITS = 1280;
    localparam longint SLAB_OFS  = longint'(SLAB_UNITS) << (RAND_BITS + 1);
    localparam int    FL_BITS    = RAND_BITS + LEN_BITS;
    localparam int    VZ_BITS    = LEN_BITS + RAND_BITS + 3;
    localparam int    Z_SHIFT    = RAND_BITS + 1;
    localparam int    Z_BITS     = VZ_BITS - Z_SHIFT;

    localparam logic signed [TRIG_BITS-1:0] Q30_ONE = TRIG_BITS'(1073741824);
    localparam logic signed [TRIG_BITS-1:0] Q30_C36 = TRIG_BITS'(868675383);
    localparam logic signed [TRIG_BITS-1:0] Q30_C72 = TRIG_BITS'(331804471);
    localparam logic signed [TRIG_BITS-1:0] Q30_S36 = TRIG_BITS'(631129609);
    localparam logic signed [TRIG_BITS-1:0] Q30_S72 = TRIG_BITS'(1021189159);

    localparam logic signed [SUM_BITS-1:0] SAT_HI =
        SUM_BITS'((longint'(1) << (COORD_BITS - 1)) - 1);
    localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

    localparam logic [REGION_BITS-1:0] REGION_WHOLE = REGION_BITS'(0);
    localparam logic [REGION_BITS-1:0] REGION_SLAB  = REGION_BITS'(1);

    typedef enum logic [2:0] {
        REG_APOTHEM  = 3'd0,
        REG_LENGTH   = 3'd1,
        REG_ORIGIN_X = 3'd2,
        REG_ORIGIN_Y = 3'd3,
        REG_ORIGIN_Z = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic        [APO_BITS-1:0] apothem;
        logic        [LEN_BITS-1:0] prism_length;
        logic signed [ORG_BITS-1:0] origin_x;
        logic signed [ORG_BITS-1:0] origin_y;
        logic signed [ORG_BITS-1:0] origin_z;
    } t_cfg;

    typedef struct packed {
        logic [NSTAGE-1:0] en;
    } t_pipe_ctl;

    function automatic logic [SEC_BITS-1:0] fn_sec_mod(input logic [SEC_BITS-1:0] s);
        return (s >= SEC_BITS'(10)) ? s - SEC_BITS'(10) : s;
    endfunction

    function automatic logic signed [TRIG_BITS-1:0] fn_cos(input logic [SEC_BITS-1:0] s);
        logic signed [TRIG_BITS-1:0] c;
        case (s)
            SEC_BITS'(0): c = Q30_ONE;
            SEC_BITS'(1): c = Q30_C36;
            SEC_BITS'(2): c = Q30_C72;
            SEC_BITS'(3): c = -Q30_C72;
            SEC_BITS'(4): c = -Q30_C36;
            SEC_BITS'(5): c = -Q30_ONE;
            SEC_BITS'(6): c = -Q30_C36;
            SEC_BITS'(7): c = -Q30_C72;
            SEC_BITS'(8): c = Q30_C72;
            SEC_BITS'(9): c = Q30_C36;
            default:      c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [TRIG_BITS-1:0] fn_sin(input logic [SEC_BITS-1:0] s);
        logic signed [TRIG_BITS-1:0] v;
        case (s)
            SEC_BITS'(1): v = Q30_S36;
            SEC_BITS'(2): v = Q30_S72;
            SEC_BITS'(3): v = Q30_S72;
            SEC_BITS'(4): v = Q30_S36;
            SEC_BITS'(6): v = -Q30_S36;
            SEC_BITS'(7): v = -Q30_S72;
            SEC_BITS'(8): v = -Q30_S72;
            SEC_BITS'(9): v = -Q30_S36;
            default:      v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] fn_sat(
        input logic signed [SUM_BITS-1:0] v
    );
        logic signed [SUM_BITS-1:0] c;
        c = v;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end
        return c[COORD_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/decagon_prism_vertex_sampler_top.sv
// Top level of the decagon prism vertex sampler: valid chain, stage enables,
// and wiring of dps_cfg_regs, dps_xy_path and dps_z_path. Depends on dps_pkg.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | region, rand_a, rand_b, sector, rand_z
//  out     | output    | o_out_valid / i_out_ready  | pos_x, pos_y, pos_z, bad_region
//  cfg     | input     | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// One transfer per cycle sustained unless the output stalls; the x/y path stages are
// fold, tangent scale, y and x products, rotation products, sums, rounding, origin.
// Synchronous reset clears the stage valid bits and the configuration registers.
// A stall on the output holds stage 8; earlier stages keep filling bubbles,
// and o_in_ready drops only once all 8 stages hold items.
`default_nettype none
`include "assert_macros.svh"
module decagon_prism_vertex_sampler_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [dps_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [dps_pkg::DATA_BITS-1:0]         pwdata,
    output logic [dps_pkg::DATA_BITS-1:0]         prdata,
    output logic                                  pready,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [dps_pkg::REGION_BITS-1:0]       i_region,
    input  logic [dps_pkg::RAND_BITS-1:0]         i_rand_a,
    input  logic [dps_pkg::RAND_BITS-1:0]         i_rand_b,
    input  logic [dps_pkg::SEC_BITS-1:0]          i_sector,
    input  logic [dps_pkg::RAND_BITS-1:0]         i_rand_z,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [dps_pkg::COORD_BITS-1:0] o_pos_x,
    output logic signed [dps_pkg::COORD_BITS-1:0] o_pos_y,
    output logic signed [dps_pkg::COORD_BITS-1:0] o_pos_z,
    output logic                                  o_bad_region
);
    import dps_pkg::*;

    t_cfg              cfg;
    t_pipe_ctl         ctl;
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_vld;

    always_comb begin
        ctl.en[NSTAGE-1] = !r_vld[NSTAGE-1] || i_out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            ctl.en[i] = !r_vld[i] || ctl.en[i+1];
        end
    end

    assign n_vld = {r_vld[NSTAGE-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 0; i < NSTAGE; i++) begin
                if (ctl.en[i]) begin
                    r_vld[i] <= n_vld[i];
                end
            end
        end
    end

    assign o_in_ready  = ctl.en[0];
    assign o_out_valid = r_vld[NSTAGE-1];

    dps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dps_xy_path u_xy (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_cfg        (cfg),
        .i_region     (i_region),
        .i_rand_a     (i_rand_a),
        .i_rand_b     (i_rand_b),
        .i_sector     (i_sector),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_bad_region (o_bad_region)
    );

    dps_z_path u_z (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_cfg    (cfg),
        .i_region (i_region),
        .i_rand_z (i_rand_z),
        .o_pos_z  (o_pos_z)
    );

    `DPS_ASSERT_IMPL(a_ready_when_out_empty, i_clk, i_rst_n, !r_vld[NSTAGE-1], o_in_ready, "ready low with empty output stage")
    `DPS_ASSERT_IMPL(a_ready_follows_sink, i_clk, i_rst_n, i_out_ready, o_in_ready, "ready low while sink takes transfer")
    `DPS_ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, !o_in_ready, &r_vld, "ready low with a bubble in the pipe")
    `DPS_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_in_valid && o_in_ready, r_vld[0], "accepted transfer not in first stage")
    `DPS_ASSERT_IMPL(a_bad_zero, i_clk, i_rst_n, o_out_valid && o_bad_region, o_pos_x == 0 && o_pos_y == 0 && o_pos_z == 0, "bad region with nonzero position")

endmodule
`default_nettype wire

FILE: hw/rtl/dps_cfg_regs.sv
// APB-style configuration registers of the vertex sampler.
// Depends on dps_pkg.
`default_nettype none
module dps_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dps_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [dps_pkg::DATA_BITS-1:0]  pwdata,
    output logic [dps_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output dps_pkg::t_cfg                  o_cfg
);
    import dps_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_BITS-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_APOTHEM:  r_cfg.apothem      <= pwdata[APO_BITS-1:0];
                REG_LENGTH:   r_cfg.prism_length <= pwdata[LEN_BITS-1:0];
                REG_ORIGIN_X: r_cfg.origin_x     <= $signed(pwdata[ORG_BITS-1:0]);
                REG_ORIGIN_Y: r_cfg.origin_y     <= $signed(pwdata[ORG_BITS-1:0]);
                REG_ORIGIN_Z: r_cfg.origin_z     <= $signed(pwdata[ORG_BITS-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_APOTHEM:  prdata = DATA_BITS'(r_cfg.apothem);
            REG_LENGTH:   prdata = DATA_BITS'(r_cfg.prism_length);
            REG_ORIGIN_X: prdata = DATA_BITS'(r_cfg.origin_x);
            REG_ORIGIN_Y: prdata = DATA_BITS'(r_cfg.origin_y);
            REG_ORIGIN_Z: prdata = DATA_BITS'(r_cfg.origin_z);
            default:      prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/dps_xy_path.sv
// Eight-stage x/y datapath: fold, scale by apothem, rotate by sector, add origin.
// Depends on dps_pkg; stage enables come from the top level.
`default_nettype none
module dps_xy_path (
    input  logic                                  i_clk,
    input  dps_pkg::t_pipe_ctl                    i_ctl,
    input  dps_pkg::t_cfg                         i_cfg,
    input  logic [dps_pkg::REGION_BITS-1:0]       i_region,
    input  logic [dps_pkg::RAND_BITS-1:0]         i_rand_a,
    input  logic [dps_pkg::RAND_BITS-1:0]         i_rand_b,
    input  logic [dps_pkg::SEC_BITS-1:0]          i_sector,
    output logic signed [dps_pkg::COORD_BITS-1:0] o_pos_x,
    output logic signed [dps_pkg::COORD_BITS-1:0] o_pos_y,
    output logic                                  o_bad_region
);
    import dps_pkg::*;

    // stage 1
    logic [FRAC_BITS-1:0]         a_ext, b_ext, ab_raw, a_f, b_f;
    logic [FRAC_BITS-1:0]         n_sum1;
    logic signed [FRAC_BITS-1:0]  n_diff1;
    logic [FRAC_BITS-1:0]         r1_sum;
    logic signed [FRAC_BITS-1:0]  r1_diff;
    logic [TPROD_BITS-1:0]        r1_tprod;
    logic [SEC_BITS-1:0]          r1_sec;
    logic                         r1_bad;
    // stage 2
    logic [TPROD_BITS-1:0]        tsum;
    logic [T_BITS-1:0]            r2_t;
    logic [YPROD_BITS-1:0]        r2_yprod;
    logic signed [FRAC_BITS-1:0]  r2_diff;
    logic [SEC_BITS-1:0]          r2_sec;
    logic                         r2_bad;
    // stage 3
    logic [YPROD_BITS-1:0]        ysum;
    logic signed [XPROD_BITS-1:0] r3_xprod;
    logic [Y0_BITS-1:0]           r3_y0;
    logic [SEC_BITS-1:0]          r3_sec;
    logic                         r3_bad;
    // stage 4
    logic [XPROD_BITS-1:0]        xsum;
    logic signed [X0_BITS-1:0]    r4_x0;
    logic [Y0_BITS-1:0]           r4_y0;
    logic signed [TRIG_BITS-1:0]  r4_cos, r4_sin;
    logic                         r4_bad;
    // stage 5
    logic signed [Y0_BITS:0]      y0_s;
    logic signed [ROT_BITS-1:0]   r5_xc, r5_ys, r5_xs, r5_yc;
    logic                         r5_bad;
    // stage 6
    logic signed [ROT_BITS-1:0]   r6_xs, r6_ys;
    logic                         r6_bad;
    // stage 7
    logic [ROT_BITS-1:0]          xr_sum, yr_sum;
    logic signed [SUM_BITS-1:0]   r7_xr, r7_yr;
    logic                         r7_bad;
    // stage 8
    logic signed [COORD_BITS-1:0] r8_x, r8_y;
    logic                         r8_bad;

    always_comb begin
        a_ext  = {1'b0, i_rand_a};
        b_ext  = {1'b0, i_rand_b};
        ab_raw = a_ext + b_ext;
        if (ab_raw > FRAC_ONE) begin
            a_f = FRAC_ONE - a_ext;
            b_f = FRAC_ONE - b_ext;
        end else begin
            a_f = a_ext;
            b_f = b_ext;
        end
        n_sum1  = a_f + b_f;
        n_diff1 = $signed(b_f - a_f);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r1_sum   <= n_sum1;
            r1_diff  <= n_diff1;
            r1_tprod <= TPROD_BITS'(i_cfg.apothem) * TPROD_BITS'(TAN18_Q24);
            r1_sec   <= fn_sec_mod(i_sector);
            r1_bad   <= !(i_region == REGION_WHOLE || i_region == REGION_SLAB);
        end
    end

    assign tsum = r1_tprod + (TPROD_BITS'(1) << (TAN_SHIFT - 1));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r2_t     <= tsum[TPROD_BITS-1:TAN_SHIFT];
            r2_yprod <= YPROD_BITS'(r1_sum) * YPROD_BITS'(i_cfg.apothem);
            r2_diff  <= r1_diff;
            r2_sec   <= r1_sec;
            r2_bad   <= r1_bad;
        end
    end

    assign ysum = r2_yprod + (YPROD_BITS'(1) << (RAND_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r3_xprod <= r2_diff * $signed({1'b0, r2_t});
            r3_y0    <= ysum[YPROD_BITS-1:RAND_BITS];
            r3_sec   <= r2_sec;
            r3_bad   <= r2_bad;
        end
    end

    assign xsum = r3_xprod + (XPROD_BITS'(1) << (X0_SHIFT - 1))
                - XPROD_BITS'(r3_xprod[XPROD_BITS-1]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r4_x0  <= $signed(xsum[XPROD_BITS-1:X0_SHIFT]);
            r4_y0  <= r3_y0;
            r4_cos <= fn_cos(r3_sec);
            r4_sin <= fn_sin(r3_sec);
            r4_bad <= r3_bad;
        end
    end

    assign y0_s = $signed({1'b0, r4_y0});

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r5_xc  <= r4_x0 * r4_cos;
            r5_ys  <= y0_s * r4_sin;
            r5_xs  <= r4_x0 * r4_sin;
            r5_yc  <= y0_s * r4_cos;
            r5_bad <= r4_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[5]) begin
            r6_xs  <= r5_xc - r5_ys;
            r6_ys  <= r5_xs + r5_yc;
            r6_bad <= r5_bad;
        end
    end

    assign xr_sum = r6_xs + (ROT_BITS'(1) << (ROT_SHIFT - 1)) - ROT_BITS'(r6_xs[ROT_BITS-1]);
    assign yr_sum = r6_ys + (ROT_BITS'(1) << (ROT_SHIFT - 1)) - ROT_BITS'(r6_ys[ROT_BITS-1]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[6]) begin
            r7_xr  <= $signed(xr_sum[ROT_BITS-1:ROT_SHIFT]);
            r7_yr  <= $signed(yr_sum[ROT_BITS-1:ROT_SHIFT]);
            r7_bad <= r6_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[7]) begin
            r8_x   <= r7_bad ? '0 : fn_sat(r7_xr + SUM_BITS'(i_cfg.origin_x));
            r8_y   <= r7_bad ? '0 : fn_sat(r7_yr + SUM_BITS'(i_cfg.origin_y));
            r8_bad <= r7_bad;
        end
    end

    assign o_pos_x      = r8_x;
    assign o_pos_y      = r8_y;
    assign o_bad_region = r8_bad;

endmodule
`default_nettype wire

FILE: hw/rtl/dps_z_path.sv
// Eight-stage z datapath: whole-length or end-slab placement, origin add.
// Depends on dps_pkg; stage enables come from the top level.
`default_nettype none
module dps_z_path (
    input  logic                                  i_clk,
    input  dps_pkg::t_pipe_ctl                    i_ctl,
    input  dps_pkg::t_cfg                         i_cfg,
    input  logic [dps_pkg::REGION_BITS-1:0]       i_region,
    input  logic [dps_pkg::RAND_BITS-1:0]         i_rand_z,
    output logic signed [dps_pkg::COORD_BITS-1:0] o_pos_z
);
    import dps_pkg::*;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] z;
        logic                       bad;
    } t_zitem;

    logic [FL_BITS-1:0]          r1_fl;
    logic signed [VZ_BITS-1:0]   r1_slab;
    logic [REGION_BITS-1:0]      r1_region;
    logic                        r1_bad;
    logic signed [VZ_BITS-1:0]   len_sh, n_v2;
    logic signed [VZ_BITS-1:0]   r2_v;
    logic                        r2_bad;
    logic [VZ_BITS-1:0]          zsum;
    t_zitem                      r3_z;
    t_zitem                      r_zd [Z_DLY];
    logic signed [COORD_BITS-1:0] r8_z;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r1_fl     <= FL_BITS'(i_rand_z) * FL_BITS'(i_cfg.prism_length);
            r1_slab   <= $signed(VZ_BITS'(i_rand_z) * VZ_BITS'(2 * SLAB_UNITS))
                       - VZ_BITS'(SLAB_OFS);
            r1_region <= i_region;
            r1_bad    <= !(i_region == REGION_WHOLE || i_region == REGION_SLAB);
        end
    end

    always_comb begin
        len_sh = VZ_BITS'(i_cfg.prism_length) << RAND_BITS;
        if (r1_region == REGION_SLAB) begin
            n_v2 = len_sh + r1_slab;
        end else begin
            n_v2 = (VZ_BITS'(r1_fl) << 1) - len_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r2_v   <= n_v2;
            r2_bad <= r1_bad;
        end
    end

    assign zsum = r2_v + (VZ_BITS'(1) << (Z_SHIFT - 1)) - VZ_BITS'(r2_v[VZ_BITS-1]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r3_z.z   <= SUM_BITS'($signed(zsum[VZ_BITS-1:Z_SHIFT]));
            r3_z.bad <= r2_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_zd[0] <= r3_z;
        end
        for (int i = 1; i < Z_DLY; i++) begin
            if (i_ctl.en[3 + i]) begin
                r_zd[i] <= r_zd[i - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[NSTAGE-1]) begin
            r8_z <= r_zd[Z_DLY-1].bad ? '0
                  : fn_sat(r_zd[Z_DLY-1].z + SUM_BITS'(i_cfg.origin_z));
        end
    end

    assign o_pos_z = r8_z;

endmodule
`default_nettype wire
